// File: rtl/ocf_pkg.sv
package ocf_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int CHANNEL_W       = 4;
    localparam int COUNT_W         = 16;
    localparam int SLOT_W          = 5;   // holds a burst slot for BURST_LEN up to 32
    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_BURST_LEN   = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam logic [SAMPLE_W-1:0] DEV_LIMIT_RESET = 16'd100;

    typedef enum logic [0:0] {
        REG_DEVIATION_LIMIT = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic [CHANNEL_W-1:0] channel;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered_value;
        logic                replaced_by_burst;
        logic [COUNT_W-1:0]  replacement_count;
    } out_item_t;

    // Work handed from the front to the back through the queue
    typedef struct packed {
        logic                 is_burst;
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  held;
        logic [COUNT_W-1:0]   repl;
    } job_t;

    // Outlier buffer write from the front
    typedef struct packed {
        logic                 en;
        logic [CHANNEL_W-1:0] channel;
        logic [SLOT_W-1:0]    slot;
        logic [SAMPLE_W-1:0]  data;
    } buf_wr_t;

    // Held value written back by the back after a burst
    typedef struct packed {
        logic                 en;
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  held;
        logic [COUNT_W-1:0]   repl;
    } held_wb_t;

endpackage

// File: rtl/ocf_queue.sv
module ocf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ocf_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output ocf_pkg::job_t head
);

    localparam int DEPTH = ocf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ocf_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ocf_front.sv
module ocf_front #(
    parameter int CHANNELS  = ocf_pkg::DEF_CHANNELS,
    parameter int BURST_LEN = ocf_pkg::DEF_BURST_LEN
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ocf_pkg::in_item_t              s_data,
    input  logic [ocf_pkg::SAMPLE_W-1:0]   dev_limit,
    input  logic                           q_full,
    output logic                           q_push,
    output ocf_pkg::job_t                  q_data,
    output ocf_pkg::buf_wr_t               buf_wr,
    input  ocf_pkg::held_wb_t              held_wb
);

    localparam int SW     = ocf_pkg::SAMPLE_W;
    localparam int RW     = ocf_pkg::COUNT_W;
    localparam int CW     = ocf_pkg::CHANNEL_W;
    localparam int SLOT_W = ocf_pkg::SLOT_W;
    localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(BURST_LEN);
    localparam int ENT_W  = SW + CNT_W + RW;
    localparam int CMP_W  = 8;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_EVAL = 2'b10
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [SW-1:0]     smp_reg;
    logic [CW-1:0]     ch_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic              ent_vld_reg;
    logic              burst_pending_reg, burst_pending_next;

    // Per-channel held value, outlier count and replacement count
    logic [ENT_W-1:0]    chan_mem [CHANNELS];
    logic [CHANNELS-1:0] chan_vld_reg;

    logic              accept;
    logic [CIW-1:0]    s_idx;
    logic              s_in_range;
    logic [CIW-1:0]    ch_idx;
    logic              in_range;
    logic [SW-1:0]     held;
    logic [CNT_W-1:0]  cnt;
    logic [RW-1:0]     repl;
    logic [SW-1:0]     diff;
    logic              is_out;
    logic              last_slot;
    logic              mem_we;
    logic [CIW-1:0]    mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;
    logic              f_we;
    logic [ENT_W-1:0]  f_wdata;

    assign s_ready    = (state_reg == F_IDLE) && !burst_pending_reg && !q_full;
    assign accept     = s_valid && s_ready;
    assign s_idx      = CIW'(s_data.channel);
    assign s_in_range = (CMP_W'(s_data.channel) < CMP_W'(CHANNELS));
    assign ch_idx     = CIW'(ch_reg);
    assign in_range   = (CMP_W'(ch_reg) < CMP_W'(CHANNELS));

    assign held = ent_vld_reg ? ent_reg[ENT_W-1 -: SW]       : '0;
    assign cnt  = ent_vld_reg ? ent_reg[RW +: CNT_W]          : '0;
    assign repl = ent_vld_reg ? ent_reg[RW-1:0]               : '0;
    assign diff = (smp_reg >= held) ? (smp_reg - held) : (held - smp_reg);
    assign is_out    = (diff > dev_limit);
    assign last_slot = (cnt == CNT_W'(BURST_LEN - 1));

    always_comb begin
        q_push  = 1'b0;
        q_data  = '0;
        buf_wr  = '0;
        f_we    = 1'b0;
        f_wdata = '0;
        burst_pending_next = burst_pending_reg;
        state_next = state_reg;
        if (held_wb.en) begin
            burst_pending_next = 1'b0;
        end
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_EVAL;
                end
            end
            F_EVAL: begin
                q_push     = 1'b1;
                state_next = F_IDLE;
                q_data.channel = ch_reg;
                if (in_range) begin
                    f_we = 1'b1;
                    if (is_out) begin
                        buf_wr.en      = 1'b1;
                        buf_wr.channel = ch_reg;
                        buf_wr.slot    = SLOT_W'(cnt);
                        buf_wr.data    = smp_reg;
                        q_data.held    = held;
                        if (last_slot) begin
                            q_data.is_burst    = 1'b1;
                            q_data.repl        = repl + 1'b1;
                            f_wdata            = {held, CNT_W'(0), repl + 1'b1};
                            burst_pending_next = 1'b1;
                        end else begin
                            q_data.repl = repl;
                            f_wdata     = {held, cnt + 1'b1, repl};
                        end
                    end else begin
                        q_data.held = smp_reg;
                        q_data.repl = repl;
                        f_wdata     = {smp_reg, CNT_W'(0), repl};
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // The back only writes while the front is stalled on a pending burst
    assign mem_we    = held_wb.en || f_we;
    assign mem_waddr = held_wb.en ? CIW'(held_wb.channel) : ch_idx;
    assign mem_wdata = held_wb.en ? {held_wb.held, CNT_W'(0), held_wb.repl} : f_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= F_IDLE;
            burst_pending_reg <= 1'b0;
            chan_vld_reg      <= '0;
        end else begin
            state_reg         <= state_next;
            burst_pending_reg <= burst_pending_next;
            if (mem_we) begin
                chan_vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_reg     <= s_data.sample;
            ch_reg      <= s_data.channel;
            ent_vld_reg <= s_in_range && chan_vld_reg[s_idx];
        end
        if (accept && s_in_range) begin
            ent_reg <= chan_mem[s_idx];
        end
        if (mem_we) begin
            chan_mem[mem_waddr] <= mem_wdata;
        end
    end

endmodule

// File: rtl/ocf_back.sv
module ocf_back #(
    parameter int CHANNELS  = ocf_pkg::DEF_CHANNELS,
    parameter int BURST_LEN = ocf_pkg::DEF_BURST_LEN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  ocf_pkg::job_t       q_head,
    output logic                q_pop,
    input  ocf_pkg::buf_wr_t    buf_wr,
    output ocf_pkg::held_wb_t   held_wb,
    output logic                m_valid,
    input  logic                m_ready,
    output ocf_pkg::out_item_t  m_data
);

    localparam int SW     = ocf_pkg::SAMPLE_W;
    localparam int RW     = ocf_pkg::COUNT_W;
    localparam int CW     = ocf_pkg::CHANNEL_W;
    localparam int DEPTH  = CHANNELS * BURST_LEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(BURST_LEN);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_LAST = 4'b0100,
        B_FIN  = 4'b1000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic [CW-1:0]       ch_reg;
    logic [RW-1:0]       repl_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SW-1:0]       rd_data_reg;
    logic                rd_vld_reg;
    logic [SW-1:0]       top_reg [4];
    logic                m_valid_reg, m_valid_next;
    ocf_pkg::out_item_t  m_data_reg, m_data_next;

    logic [SW-1:0]       buf_mem [DEPTH];

    logic                out_free;
    logic                rd_en;
    logic                start;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [SW:0]         mid_sum;
    logic [SW-1:0]       mean;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign rd_addr = AW'(ch_reg) * AW'(BURST_LEN) + AW'(idx_reg);
    assign wr_addr = AW'(buf_wr.channel) * AW'(BURST_LEN) + AW'(buf_wr.slot);

    // Third and fourth largest, summed at 17 bits
    assign mid_sum = {1'b0, top_reg[2]} + {1'b0, top_reg[3]};
    assign mean    = mid_sum[SW:1];

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        start        = 1'b0;
        held_wb      = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_not_empty && out_free) begin
                    q_pop = 1'b1;
                    if (q_head.is_burst) begin
                        start      = 1'b1;
                        idx_next   = '0;
                        state_next = B_READ;
                    end else begin
                        m_valid_next                  = 1'b1;
                        m_data_next.filtered_value    = q_head.held;
                        m_data_next.replaced_by_burst = 1'b0;
                        m_data_next.replacement_count = q_head.repl;
                    end
                end
            end
            B_READ: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(BURST_LEN - 1)) begin
                    state_next = B_LAST;
                end
            end
            B_LAST: begin
                state_next = B_FIN;
            end
            B_FIN: begin
                if (out_free) begin
                    held_wb.en                    = 1'b1;
                    held_wb.channel               = ch_reg;
                    held_wb.held                  = mean;
                    held_wb.repl                  = repl_reg;
                    m_valid_next                  = 1'b1;
                    m_data_next.filtered_value    = mean;
                    m_data_next.replaced_by_burst = 1'b1;
                    m_data_next.replacement_count = repl_reg;
                    state_next                    = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        idx_reg    <= idx_next;
        if (start) begin
            ch_reg   <= q_head.channel;
            repl_reg <= q_head.repl;
        end
        if (buf_wr.en) begin
            buf_mem[wr_addr] <= buf_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    // Running top four, largest first; zeros drop out once four entries are in
    always_ff @(posedge aclk) begin
        if (start) begin
            for (int k = 0; k < 4; k++) begin
                top_reg[k] <= '0;
            end
        end else if (rd_vld_reg) begin
            top_reg[0] <= (rd_data_reg > top_reg[0]) ? rd_data_reg : top_reg[0];
            for (int k = 1; k < 4; k++) begin
                if (rd_data_reg > top_reg[k-1]) begin
                    top_reg[k] <= top_reg[k-1];
                end else if (rd_data_reg > top_reg[k]) begin
                    top_reg[k] <= rd_data_reg;
                end
            end
        end
    end

endmodule

// File: rtl/outlier_confirm_channel_filter_unit.sv
// Channel  | Direction | Handshake                | Payload
// s_       | in        | s_valid / s_ready        | s_data  (sample, channel)
// m_       | out       | m_valid / m_ready        | m_data  (filtered_value, replaced_by_burst,
//          |           |                          |          replacement_count)
// APB      | in        | psel / penable / pready  | paddr, pwdata, prdata (deviation_limit at 0)
//
// An item that does not complete a burst is accepted and then evaluated in the front
// against the channel state read from the per-channel store.
// For an item that completes a burst, the back reads the channel's outlier buffer
// one entry a cycle through its single read port.
// Reset is synchronous on aresetn; all channel state reads as zero after reset.
// A stalled m_ready holds items in the output register and the 2-entry queue; the
// front stops taking items when the queue is full or a burst is still being resolved.
module outlier_confirm_channel_filter_unit #(
    parameter int CHANNELS  = ocf_pkg::DEF_CHANNELS,
    parameter int BURST_LEN = ocf_pkg::DEF_BURST_LEN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ocf_pkg::in_item_t             s_data,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output ocf_pkg::out_item_t            m_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ocf_pkg::PADDR_W-1:0]   paddr,
    input  logic [ocf_pkg::PDATA_W-1:0]   pwdata,
    output logic [ocf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SW = ocf_pkg::SAMPLE_W;
    localparam int DW = ocf_pkg::PDATA_W;

    logic [SW-1:0]       dev_limit_reg;
    logic                cfg_wr;
    logic                reg_hit;

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_not_empty;
    ocf_pkg::job_t       q_in;
    ocf_pkg::job_t       q_head;
    ocf_pkg::buf_wr_t    buf_wr;
    ocf_pkg::held_wb_t   held_wb;

    // Register decode: word index is paddr[2]; only word 0 exists
    assign reg_hit = (paddr[2] == ocf_pkg::REG_DEVIATION_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DW'(dev_limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_limit_reg <= ocf_pkg::DEV_LIMIT_RESET;
        end else if (cfg_wr) begin
            dev_limit_reg <= pwdata[SW-1:0];
        end
    end

    // Front: reads channel state, classifies in-limit / outlier / burst end,
    // updates the channel store and the outlier buffer
    ocf_front #(
        .CHANNELS  (CHANNELS),
        .BURST_LEN (BURST_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .dev_limit (dev_limit_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .buf_wr    (buf_wr),
        .held_wb   (held_wb)
    );

    ocf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: forwards plain results, resolves bursts by a top-four scan of the buffer
    ocf_back #(
        .CHANNELS  (CHANNELS),
        .BURST_LEN (BURST_LEN)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .buf_wr      (buf_wr),
        .held_wb     (held_wb),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
